// ===== design/lmaf_pkg.sv =====
// ----------------------------------------------------------------------------
// lmaf_pkg
// Shared types and constants of the label mask adjacency flagger: request
// codes, register indexes, payload structs, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lmaf_pkg;

  // Field widths fixed by the item format
  localparam int LABEL_W     = 12;
  localparam int REQ_W       = 2;
  localparam int ROW_WIDTH_W = 12;
  localparam int ROW_COUNT_W = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PIXEL = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd1;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 12'd2048;
  localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RST = 16'd1;

  // Neighbour slots in the pending mark list
  localparam int NB_CUR   = 0;
  localparam int NB_LEFT  = 1;
  localparam int NB_UP    = 2;
  localparam int NB_UL    = 3;
  localparam int NB_UR    = 4;
  localparam int NB_COUNT = 5;
  localparam int NB_SEL_W = 3;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [LABEL_W-1:0] label;
    logic               masked;
  } in_item_t;

  typedef struct packed {
    logic [LABEL_W-1:0] queried_label;
    logic               touches_mask;
  } out_item_t;

  // One stored pixel: mask bit over label
  typedef struct packed {
    logic               masked;
    logic [LABEL_W-1:0] label;
  } pix_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PIX_POS,
    ST_PIX_UP,
    ST_PIX_EVAL,
    ST_PIX_MARK,
    ST_QRY_RD,
    ST_QRY_OUT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic clear_step;
    logic pos_step;
    logic up_step;
    logic eval_step;
    logic mark_step;
    logic query_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic eval_any;
    logic marks_more;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/lmaf_ram.sv =====
// ----------------------------------------------------------------------------
// lmaf_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lmaf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/lmaf_ctrl.sv =====
// ----------------------------------------------------------------------------
// lmaf_ctrl
// Controller: sequences the table clearing sweep, the pixel steps
// (position, line reads, evaluation, flag writes) and queries.
// ----------------------------------------------------------------------------
`default_nettype none

module lmaf_ctrl
  import lmaf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [REQ_W-1:0] req_type,
  input  wire sts_t             sts,
  output logic                  busy,
  output cmd_t                  cmd
);

  state_t state_r, state_nxt;

  // State register; reset starts with the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (req_type)
            REQ_PIXEL: state_nxt = ST_PIX_POS;
            REQ_QUERY: state_nxt = ST_QRY_RD;
            REQ_CLEAR: state_nxt = ST_CLEAR;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_PIX_POS:  state_nxt = ST_PIX_UP;
      ST_PIX_UP:   state_nxt = ST_PIX_EVAL;
      ST_PIX_EVAL: state_nxt = sts.eval_any ? ST_PIX_MARK : ST_IDLE;
      ST_PIX_MARK: begin
        if (!sts.marks_more) state_nxt = ST_IDLE;
      end
      ST_QRY_RD:   state_nxt = ST_QRY_OUT;
      ST_QRY_OUT:  state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd            = '0;
    busy           = (state_r != ST_IDLE);
    cmd.load_item  = (state_r == ST_IDLE) && start;
    case (state_r)
      ST_CLEAR:    cmd.clear_step = 1'b1;
      ST_PIX_POS:  cmd.pos_step   = 1'b1;
      ST_PIX_UP:   cmd.up_step    = 1'b1;
      ST_PIX_EVAL: cmd.eval_step  = 1'b1;
      ST_PIX_MARK: cmd.mark_step  = 1'b1;
      ST_QRY_OUT:  cmd.query_out  = 1'b1;
      default:     ;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/lmaf_dp.sv =====
// ----------------------------------------------------------------------------
// lmaf_dp
// Datapath: configuration registers, image position, line store, left and
// upper-left pixels, neighbour pair checks, pending flag writes, flag table
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lmaf_dp
  import lmaf_pkg::*;
#(
  parameter int LABEL_COUNT = 4096,
  parameter int MAX_WIDTH   = 2048
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cmd_t                   cmd,
  output sts_t                        sts,
  input  wire in_item_t               in_data,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  output logic                        out_valid,
  output out_item_t                   out_data
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CNT_W = AW + 1;
  localparam int LA    = $clog2(LABEL_COUNT);
  localparam int PIX_W = $bits(pix_t);

  function automatic logic lbl_ok(input logic [LABEL_W-1:0] l);
    return (l != '0) && (32'(l) < LABEL_COUNT);
  endfunction

  // Configuration
  logic [ROW_WIDTH_W-1:0] row_width_r;
  logic [ROW_COUNT_W-1:0] row_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RST;
      row_count_r <= ROW_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_WIDTH: row_width_r <= cfg_wdata[ROW_WIDTH_W-1:0];
        REG_ROW_COUNT: row_count_r <= cfg_wdata[ROW_COUNT_W-1:0];
        default:       ;
      endcase
    end
  end

  // Effective width and row count
  logic [CNT_W-1:0]       eff_w;
  logic [ROW_COUNT_W-1:0] eff_rc;

  always_comb begin
    if (row_width_r == '0) begin
      eff_w = CNT_W'(1);
    end else if (32'(row_width_r) > MAX_WIDTH) begin
      eff_w = CNT_W'(MAX_WIDTH);
    end else begin
      eff_w = CNT_W'(row_width_r);
    end
    eff_rc = (row_count_r == '0) ? ROW_COUNT_W'(1) : row_count_r;
  end

  // Captured transaction
  in_item_t item_r;
  pix_t     cur;

  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_data;
  end

  assign cur = '{masked: item_r.masked, label: item_r.label};

  // Position and neighbour registers
  logic [AW-1:0]          col_r, col_nxt, col_n;
  logic [ROW_COUNT_W-1:0] row_r, row_nxt, row_n, row_a, row_p1;
  logic [CNT_W-1:0]       col_p1;
  logic                   wrap_in;
  pix_t                   left_r, left_nxt, ul_r, ul_nxt, up_r, ur;
  logic [PIX_W-1:0]       line_rdata;

  // Position of the incoming pixel after a shrink of width or row count
  always_comb begin
    wrap_in = ({1'b0, col_r} >= eff_w);
    row_a   = wrap_in ? row_r + ROW_COUNT_W'(1) : row_r;
    col_n   = wrap_in ? '0 : col_r;
    row_n   = (row_a >= eff_rc) ? '0 : row_a;
    col_p1  = {1'b0, col_r} + CNT_W'(1);
    row_p1  = row_r + ROW_COUNT_W'(1);
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    left_nxt = left_r;
    ul_nxt   = ul_r;
    if (cmd.clear_step) begin
      col_nxt  = '0;
      row_nxt  = '0;
      left_nxt = '0;
      ul_nxt   = '0;
    end else if (cmd.pos_step) begin
      col_nxt = col_n;
      row_nxt = row_n;
    end else if (cmd.eval_step) begin
      left_nxt = cur;
      ul_nxt   = up_r;
      if (col_p1 >= eff_w) begin
        col_nxt = '0;
        row_nxt = (row_p1 >= eff_rc) ? '0 : row_p1;
      end else begin
        col_nxt = col_p1[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
      ul_r   <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      left_r <= left_nxt;
      ul_r   <= ul_nxt;
    end
  end

  // Pixel above, taken the cycle after its read
  always_ff @(posedge clk) begin
    if (cmd.up_step) up_r <= pix_t'(line_rdata);
  end

  assign ur = pix_t'(line_rdata);

  // Line store: read above in the position step, upper-right next, write last
  lmaf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (cmd.eval_step),
    .waddr (col_r),
    .wdata (PIX_W'(cur)),
    .raddr (cmd.up_step ? col_p1[AW-1:0] : col_n),
    .rdata (line_rdata)
  );

  // Neighbour pair checks
  logic                v_left, v_up, v_ul, v_ur;
  logic [NB_COUNT-1:0] eval_marks;
  logic [LABEL_W-1:0]  eval_lbl [NB_COUNT];

  always_comb begin
    v_left = (col_r != '0);
    v_up   = (row_r != '0);
    v_ul   = v_up && v_left;
    v_ur   = v_up && (col_p1 < eff_w);

    eval_lbl[NB_CUR]  = cur.label;
    eval_lbl[NB_LEFT] = left_r.label;
    eval_lbl[NB_UP]   = up_r.label;
    eval_lbl[NB_UL]   = ul_r.label;
    eval_lbl[NB_UR]   = ur.label;

    eval_marks = '0;
    if (!cur.masked) begin
      eval_marks[NB_CUR] = lbl_ok(cur.label) &&
                           ((v_left && left_r.masked) || (v_up && up_r.masked) ||
                            (v_ul && ul_r.masked) || (v_ur && ur.masked));
    end else begin
      eval_marks[NB_LEFT] = v_left && !left_r.masked && lbl_ok(left_r.label);
      eval_marks[NB_UP]   = v_up   && !up_r.masked   && lbl_ok(up_r.label);
      eval_marks[NB_UL]   = v_ul   && !ul_r.masked   && lbl_ok(ul_r.label);
      eval_marks[NB_UR]   = v_ur   && !ur.masked     && lbl_ok(ur.label);
    end
  end

  // Pending flag writes, one per cycle through the table's single write port
  logic [NB_COUNT-1:0] marks_r, marks_nxt;
  logic [LABEL_W-1:0]  mark_lbl_r [NB_COUNT];
  logic [NB_SEL_W-1:0] mark_sel;

  always_comb begin
    mark_sel = '0;
    for (int i = NB_COUNT - 1; i >= 0; i--) begin
      if (marks_r[i]) mark_sel = NB_SEL_W'(i);
    end
  end

  always_comb begin
    marks_nxt = marks_r;
    if (cmd.eval_step) begin
      marks_nxt = eval_marks;
    end else if (cmd.mark_step) begin
      marks_nxt = marks_r & ~(NB_COUNT'(1) << mark_sel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r <= '0;
    end else begin
      marks_r <= marks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_step) mark_lbl_r <= eval_lbl;
  end

  // Clearing sweep counter
  logic [LA-1:0] clr_cnt_r, clr_cnt_nxt;

  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    if (cmd.clear_step) begin
      clr_cnt_nxt = sts.clr_last ? '0 : clr_cnt_r + LA'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Flag table
  logic          flag_rdata;
  logic [LA-1:0] flag_waddr;

  assign flag_waddr = cmd.clear_step ? clr_cnt_r : LA'(32'(mark_lbl_r[mark_sel]));

  lmaf_ram #(
    .WIDTH (1),
    .DEPTH (LABEL_COUNT)
  ) u_flag_ram (
    .clk   (clk),
    .we    (cmd.clear_step | cmd.mark_step),
    .waddr (flag_waddr),
    .wdata (cmd.mark_step),
    .raddr (LA'(32'(item_r.label))),
    .rdata (flag_rdata)
  );

  // Status to the controller
  always_comb begin
    sts.clr_last   = (clr_cnt_r == LA'(LABEL_COUNT - 1));
    sts.eval_any   = |eval_marks;
    sts.marks_more = |(marks_r & (marks_r - NB_COUNT'(1)));
  end

  // Result register
  out_item_t out_data_r, out_data_nxt;
  logic      out_valid_r;

  always_comb begin
    out_data_nxt.queried_label = item_r.label;
    out_data_nxt.touches_mask  = (32'(item_r.label) < LABEL_COUNT) && flag_rdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.query_out;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_out) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== design/label_mask_adjacency_flagger_top.sv =====
// ----------------------------------------------------------------------------
// label_mask_adjacency_flagger_top
// Pixels arrive in raster order and are taken while busy is low. A pixel passes
// through the accepting cycle, a position step that reads the line entry above,
// a step that reads the upper-right entry through the line store's single read
// port, and an evaluation step that writes the line, then one flag write step
// for each flag write it raises, up to 4, since all flag writes share the flag
// table's single write port. A query passes through the accepting cycle, a read
// step and an output step; its result appears on out_data with out_valid high
// for exactly one cycle, the first cycle with busy low again; the receiver
// cannot stall it. After reset and after every clear request the flag table is
// swept to zero, one entry per cycle, with busy high until the sweep ends;
// configuration writes are taken at any time but belong between transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module label_mask_adjacency_flagger_top
  import lmaf_pkg::*;
#(
  parameter int LABEL_COUNT = 4096,
  parameter int MAX_WIDTH   = 2048
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;
  logic known_req;

  lmaf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_data.req_type),
    .sts      (sts),
    .busy     (busy),
    .cmd      (cmd)
  );

  lmaf_dp #(
    .LABEL_COUNT (LABEL_COUNT),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Request codes the block acts on
  assign known_req = in_data.req_type inside {REQ_PIXEL, REQ_QUERY, REQ_CLEAR};

  // Results never come back to back
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // A result follows only the query output step
  a_out_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.query_out))
    else $error("result without a query");

  // Any known request leaves the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && known_req) |=> busy)
    else $error("accepted transaction not started");

  // Flag-setting writes only happen while a mark is pending
  a_mark_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark_step |-> !cmd.clear_step && $past(cmd.eval_step || cmd.mark_step))
    else $error("flag write outside a pixel");

endmodule

`default_nettype wire
